// ===== sv/lru_cache_slot_picker_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LRU_CACHE_SLOT_PICKER_UNIT_ASSERT_SVH
`define LRU_CACHE_SLOT_PICKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LCSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LCSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcsp_pkg.sv =====
package lcsp_pkg;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;

  // starting value of the oldest-stamp search
  localparam logic [TIME_W-1:0] AGE_START = 32'hffff_ffff;

  // result codes
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUTCOME_HIT   = 2'd0;
  localparam outcome_t OUTCOME_FILL  = 2'd1;
  localparam outcome_t OUTCOME_EVICT = 2'd2;

endpackage

// ===== sv/lcsp_ram.sv =====
module lcsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lru_cache_slot_picker_unit.sv =====
// Scan: reads the valid slots 0..count-1 in index order through the registered RAM read,
//   stops early on a tag hit, then goes to ST_POST and posts the result once the output is free.
// One request at a time: req_stall is high outside ST_IDLE, so a new request waits until the
//   last result is posted; the single read port of the tag/stamp RAM gives one slot read per cycle.
// Reset (synchronous, active high): fill count, state and result valid cleared;
//   RAM contents stay undefined, no clearing pass.
module lru_cache_slot_picker_unit #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [lcsp_pkg::KEY_W-1:0]    key,
  input  logic [lcsp_pkg::TIME_W-1:0]   now_time,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [lcsp_pkg::SLOT_W-1:0]   slot,
  output lcsp_pkg::outcome_t            outcome
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = lcsp_pkg::TIME_W;
  localparam int RW = KEY_BITS + TW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_POST = 3'b100
  } state_t;

  state_t state, state_next;

  logic [KEY_BITS-1:0] key_tag;
  logic [KEY_BITS-1:0] tag_q;
  logic [TW-1:0]       time_q;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_idx;
  logic                chk_vld;
  logic [IW-1:0]       chk_idx;
  logic [TW-1:0]       oldest;
  logic [IW-1:0]       victim;
  logic [IW-1:0]       pend_idx;
  lcsp_pkg::outcome_t  pend_outcome;
  logic [IW-1:0]       res_idx;

  logic                req_acc;
  logic                issue;
  logic                hit;
  logic                full;
  logic                decide;
  logic                out_free;
  logic [RW-1:0]       rdata;
  logic [KEY_BITS-1:0] rd_tag;
  logic [TW-1:0]       rd_stamp;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  lcsp_pkg::outcome_t  dec_outcome;

  // keep the low KEY_BITS of the key, zero-extend when wider
  generate
    if (KEY_BITS <= lcsp_pkg::KEY_W) begin : g_key_cut
      assign key_tag = key[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign key_tag = {{(KEY_BITS - lcsp_pkg::KEY_W){1'b0}}, key};
    end
  endgenerate

  // result slot index, low SLOT_W bits, zero-extended when narrower
  generate
    if (IW >= lcsp_pkg::SLOT_W) begin : g_slot_cut
      assign slot = res_idx[lcsp_pkg::SLOT_W-1:0];
    end else begin : g_slot_ext
      assign slot = {{(lcsp_pkg::SLOT_W - IW){1'b0}}, res_idx};
    end
  endgenerate

  // tag and stamp live side by side in one RAM word
  lcsp_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({tag_q, time_q}),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rdata)
  );

  assign rd_tag   = rdata[RW-1:TW];
  assign rd_stamp = rdata[TW-1:0];

  // scan control: slots fill in index order, so valid slots are 0..count-1
  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign issue     = (rd_idx < count);
  assign full      = (count == CW'(SLOTS));
  assign hit       = chk_vld && (rd_tag == tag_q);
  assign decide    = (state == ST_SCAN) && (hit || (!issue && !chk_vld));
  assign out_free  = !res_valid || !res_stall;

  // pick the slot to write back
  always_comb begin
    priority if (hit) begin
      ram_waddr   = chk_idx;
      dec_outcome = lcsp_pkg::OUTCOME_HIT;
    end else if (!full) begin
      ram_waddr   = count[IW-1:0];
      dec_outcome = lcsp_pkg::OUTCOME_FILL;
    end else begin
      ram_waddr   = victim;
      dec_outcome = lcsp_pkg::OUTCOME_EVICT;
    end
  end

  assign ram_we = decide;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (decide) state_next = ST_POST;
      end
      ST_POST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      chk_vld   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_acc || decide) begin
        chk_vld <= 1'b0;
      end else if (state == ST_SCAN) begin
        chk_vld <= issue;
      end
      if (decide && !hit && !full) begin
        count <= count + CW'(1);
      end
      if (state == ST_POST && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      tag_q  <= key_tag;
      time_q <= now_time;
      rd_idx <= '0;
      oldest <= lcsp_pkg::AGE_START;
      victim <= '0;
    end else if (state == ST_SCAN) begin
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      chk_idx <= rd_idx[IW-1:0];
      // track the strictly oldest stamp, lowest index wins a tie
      if (chk_vld && !hit && (rd_stamp < oldest)) begin
        oldest <= rd_stamp;
        victim <= chk_idx;
      end
    end
    if (decide) begin
      pend_idx     <= ram_waddr;
      pend_outcome <= dec_outcome;
    end
    if (state == ST_POST && out_free) begin
      res_idx <= pend_idx;
      outcome <= pend_outcome;
    end
  end

endmodule

// ===== sv/lcsp_checker.sv =====
`include "lru_cache_slot_picker_unit_assert.svh"

module lcsp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic [lcsp_pkg::SLOT_W-1:0] slot,
  input lcsp_pkg::outcome_t          outcome
);

  // a held result keeps its payload
  `LCSP_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(slot) && $stable(outcome), "result changed while stalled")

  // only the three defined result codes appear
  `LCSP_ASSERT_NOW(a_outcome_code, res_valid, outcome == lcsp_pkg::OUTCOME_HIT || outcome == lcsp_pkg::OUTCOME_FILL || outcome == lcsp_pkg::OUTCOME_EVICT, "undefined outcome code")

  // one request at a time: busy right after an accept
  `LCSP_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request accepted during scan")

endmodule

bind lru_cache_slot_picker_unit lcsp_checker u_lcsp_checker (.*);
